[hw/rtl/rgb2yuv_pkg.sv]
`default_nettype none
package rgb2yuv_pkg;

	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 1;
	localparam int PIX_W     = 8;
	localparam int CH_W      = 9;
	localparam int SUM_W     = 10;
	localparam int ACC_W     = 11;
	localparam int Y_W       = 24;
	localparam int UV_W      = 25;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

	// luma coefficients, 16 fractional bits, with the rounding half
	localparam logic [Y_W-1:0] Y_R   = 24'd19595;
	localparam logic [Y_W-1:0] Y_G   = 24'd38470;
	localparam logic [Y_W-1:0] Y_B   = 24'd7471;
	localparam logic [Y_W-1:0] Y_RND = 24'd32768;

	// chroma coefficient magnitudes; offset is 128.5 in the same format
	localparam logic [UV_W-1:0] UV_OFS = 25'd8421376;
	localparam logic [UV_W-1:0] U_R    = 25'd11076;
	localparam logic [UV_W-1:0] U_G    = 25'd21692;
	localparam logic [UV_W-1:0] U_B    = 25'd32768;
	localparam logic [UV_W-1:0] V_R    = 25'd32768;
	localparam logic [UV_W-1:0] V_G    = 25'd27460;
	localparam logic [UV_W-1:0] V_B    = 25'd5308;

	localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

	typedef struct packed {
		logic col_odd;
		logic last_col;
		logic row_odd;
		logic last_row;
		logic frame_end;
	} pix_ctl_t;

endpackage
`default_nettype wire

[hw/rtl/rgb_to_yuv420_converter_top.sv]
`default_nettype none
// Channel   Handshake              Payload
// in        in_valid / in_ready    red, green, blue
// out       out_valid / out_ready  luma, chroma_valid, blue_diff, red_diff, frame_end
// cfg       cfg_write_en           cfg_index, cfg_data
//
// One pixel per cycle sustained while the output is not stalled; each pixel passes the stages below in order.
// Stages: position and line store read, colour matrix, block sum and output register.
// The line store holds top-row chroma sums, one entry per block column; a write and
// a read of the same entry on one edge are forwarded.
// Reset is asynchronous and needs no clearing pass; the line store is written before read.
// A stalled output holds the whole pipeline, the line store read included.
module rgb_to_yuv420_converter_top #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_write_en,
	input  wire logic [rgb2yuv_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [rgb2yuv_pkg::CFG_W-1:0]          cfg_data,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic [rgb2yuv_pkg::PIX_W-1:0]          red,
	input  wire logic [rgb2yuv_pkg::PIX_W-1:0]          green,
	input  wire logic [rgb2yuv_pkg::PIX_W-1:0]          blue,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic [rgb2yuv_pkg::PIX_W-1:0]               luma,
	output logic                                        chroma_valid,
	output logic [rgb2yuv_pkg::PIX_W-1:0]               blue_diff,
	output logic [rgb2yuv_pkg::PIX_W-1:0]               red_diff,
	output logic                                        frame_end
);
	import rgb2yuv_pkg::*;

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int WSW   = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
	localparam int HSW   = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;
	localparam int DEPTH = (MAX_WIDTH + 1) / 2;
	localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [CFG_W-1:0] frame_width_q, frame_height_q;
	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic [2*CH_W-1:0] held_pair_q;

	logic [WSW-1:0] lim_w;
	logic [HSW-1:0] lim_h;
	logic           last_col, last_row, adv, accept;

	logic             valid_s1, valid_s2, out_valid_q;
	logic [PIX_W-1:0] red_s1, green_s1, blue_s1;
	pix_ctl_t         ctl_s1, ctl_s2;
	logic [IW-1:0]    idx_s1, idx_s2;
	logic [PIX_W-1:0] y_s2;
	logic [CH_W-1:0]  u_s2, v_s2;

	logic [2*SUM_W-1:0] line_mem [DEPTH];
	logic [2*SUM_W-1:0] rd_data_q, fwd_data_q;
	logic               fwd_hit_q;

	logic [Y_W-1:0]   y_full;
	logic [UV_W-1:0]  u_full, v_full;

	logic [SUM_W-1:0]   su, sv;
	logic [ACC_W-1:0]   au, av, su_sh, sv_sh;
	logic [2*SUM_W-1:0] line_entry;
	logic [1:0]         shift;
	logic               hold_left, wr_top, blk_done, wr_en;
	logic [PIX_W-1:0]   uo, vo;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;
	assign accept   = in_valid && adv;

	// effective size: zero counts as one, oversize clamps to the maximum
	always_comb begin
		if (frame_width_q == '0) begin
			lim_w = '0;
		end else if (WSW'(frame_width_q) > WSW'(MAX_WIDTH)) begin
			lim_w = WSW'(MAX_WIDTH - 1);
		end else begin
			lim_w = WSW'(frame_width_q) - WSW'(1);
		end
		if (frame_height_q == '0) begin
			lim_h = '0;
		end else if (HSW'(frame_height_q) > HSW'(MAX_HEIGHT)) begin
			lim_h = HSW'(MAX_HEIGHT - 1);
		end else begin
			lim_h = HSW'(frame_height_q) - HSW'(1);
		end
	end

	assign last_col = WSW'(col_q) >= lim_w;
	assign last_row = HSW'(row_q) >= lim_h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			if (adv) begin
				valid_s1    <= in_valid;
				valid_s2    <= valid_s1;
				out_valid_q <= valid_s2;
			end
		end
	end

	// stage 1: capture pixel and its place in the block
	always_ff @(posedge clk) begin
		if (adv) begin
			red_s1             <= red;
			green_s1           <= green;
			blue_s1            <= blue;
			idx_s1             <= IW'(col_q >> 1);
			ctl_s1.col_odd     <= col_q[0];
			ctl_s1.last_col    <= last_col;
			ctl_s1.row_odd     <= row_q[0];
			ctl_s1.last_row    <= last_row;
			ctl_s1.frame_end   <= last_col && last_row;
		end
	end

	// colour matrix; chroma terms stay positive so modular subtraction is exact
	always_comb begin
		y_full = Y_R * Y_W'(red_s1) + Y_G * Y_W'(green_s1) + Y_B * Y_W'(blue_s1) + Y_RND;
		u_full = UV_OFS + U_B * UV_W'(blue_s1) - U_R * UV_W'(red_s1)
			- U_G * UV_W'(green_s1);
		v_full = UV_OFS + V_R * UV_W'(red_s1) - V_G * UV_W'(green_s1)
			- V_B * UV_W'(blue_s1);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			y_s2   <= y_full[Y_W-1 -: PIX_W];
			u_s2   <= u_full[UV_W-1 -: CH_W];
			v_s2   <= v_full[UV_W-1 -: CH_W];
			ctl_s2 <= ctl_s1;
			idx_s2 <= idx_s1;
		end
	end

	// line store: read for the pixel in stage 1, write from stage 2
	always_ff @(posedge clk) begin
		if (adv) begin
			rd_data_q  <= line_mem[idx_s1];
			fwd_hit_q  <= wr_en && (idx_s2 == idx_s1);
			fwd_data_q <= {su, sv};
		end
		if (wr_en) begin
			line_mem[idx_s2] <= {su, sv};
		end
	end

	assign line_entry = fwd_hit_q ? fwd_data_q : rd_data_q;

	// stage 2: block sums
	always_comb begin
		hold_left = !ctl_s2.col_odd && !ctl_s2.last_col;
		wr_top    = !hold_left && !ctl_s2.row_odd && !ctl_s2.last_row;
		blk_done  = !hold_left && !wr_top;
		wr_en     = valid_s2 && adv && wr_top;

		su = SUM_W'(u_s2);
		sv = SUM_W'(v_s2);
		if (ctl_s2.col_odd) begin
			su = su + SUM_W'(held_pair_q[2*CH_W-1 -: CH_W]);
			sv = sv + SUM_W'(held_pair_q[CH_W-1:0]);
		end
		au    = ACC_W'(su);
		av    = ACC_W'(sv);
		shift = {1'b0, ctl_s2.col_odd};
		if (ctl_s2.row_odd) begin
			au    = au + ACC_W'(line_entry[2*SUM_W-1 -: SUM_W]);
			av    = av + ACC_W'(line_entry[SUM_W-1:0]);
			shift = shift + 2'd1;
		end
		su_sh = au >> shift;
		sv_sh = av >> shift;
		uo    = (su_sh > ACC_W'(PIX_MAX)) ? PIX_MAX : su_sh[PIX_W-1:0];
		vo    = (sv_sh > ACC_W'(PIX_MAX)) ? PIX_MAX : sv_sh[PIX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_pair_q <= '0;
		end else if (valid_s2 && adv && hold_left) begin
			held_pair_q <= {u_s2, v_s2};
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (adv) begin
			luma         <= y_s2;
			chroma_valid <= blk_done;
			blue_diff    <= blk_done ? uo : '0;
			red_diff     <= blk_done ? vo : '0;
			frame_end    <= ctl_s2.frame_end;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps
module tb;
	import rgb2yuv_pkg::*;

	localparam int MAX_W = 4096;
	localparam int MAX_H = 4096;
	localparam int RANDOM_PIXELS = 1100;
	localparam int SHOW_LIMIT = 40;
	localparam int STORE_COLS = (MAX_W + 1) / 2;

	// BT.601 in 16 fractional bits
	localparam int unsigned KY_R = 19595;
	localparam int unsigned KY_G = 38470;
	localparam int unsigned KY_B = 7471;
	localparam int unsigned KY_HALF = 32768;
	localparam int unsigned KU_R = 11076;
	localparam int unsigned KU_G = 21692;
	localparam int unsigned KU_B = 32768;
	localparam int unsigned KV_R = 32768;
	localparam int unsigned KV_G = 27460;
	localparam int unsigned KV_B = 5308;
	localparam int unsigned K_CHROMA_BIAS = 8421376;

	localparam logic [23:0] RGB_BLACK = 24'h000000;
	localparam logic [23:0] RGB_WHITE = 24'hFFFFFF;
	localparam logic [23:0] RGB_RED   = 24'hFF0000;
	localparam logic [23:0] RGB_GREEN = 24'h00FF00;
	localparam logic [23:0] RGB_BLUE  = 24'h0000FF;

	typedef struct packed {
		logic [PIX_W-1:0] luma;
		logic             chroma_valid;
		logic [PIX_W-1:0] blue_diff;
		logic [PIX_W-1:0] red_diff;
		logic             frame_end;
	} yuv_t;

	typedef struct packed {
		logic             set_size;
		logic [CFG_W-1:0] width;
		logic [CFG_W-1:0] height;
		logic [23:0]      rgb;
		logic             typed;
		yuv_t             want;
	} pixel_row_t;

	localparam yuv_t NO_RESULT = '0;

	// 1x1 frames, a saturating 2x2 block, a 3x3 frame with odd edges, then zero sizes
	localparam pixel_row_t DIRECTED_ROWS [18] = '{
		'{1'b1, 13'd1, 13'd1, RGB_RED,   1'b1, '{8'd76,  1'b1, 8'd85,  8'd255, 1'b1}},
		'{1'b0, 13'd0, 13'd0, RGB_BLUE,  1'b1, '{8'd29,  1'b1, 8'd255, 8'd107, 1'b1}},
		'{1'b0, 13'd0, 13'd0, RGB_BLACK, 1'b1, '{8'd0,   1'b1, 8'd128, 8'd128, 1'b1}},
		'{1'b0, 13'd0, 13'd0, RGB_WHITE, 1'b1, '{8'd255, 1'b1, 8'd128, 8'd128, 1'b1}},
		'{1'b1, 13'd2, 13'd2, RGB_RED,   1'b1, '{8'd76,  1'b0, 8'd0,   8'd0,   1'b0}},
		'{1'b0, 13'd0, 13'd0, RGB_RED,   1'b1, '{8'd76,  1'b0, 8'd0,   8'd0,   1'b0}},
		'{1'b0, 13'd0, 13'd0, RGB_RED,   1'b1, '{8'd76,  1'b0, 8'd0,   8'd0,   1'b0}},
		'{1'b0, 13'd0, 13'd0, RGB_RED,   1'b1, '{8'd76,  1'b1, 8'd85,  8'd255, 1'b1}},
		'{1'b1, 13'd3, 13'd3, RGB_GREEN, 1'b0, NO_RESULT},
		'{1'b0, 13'd0, 13'd0, 24'h123456, 1'b0, NO_RESULT},
		'{1'b0, 13'd0, 13'd0, RGB_WHITE, 1'b0, NO_RESULT},
		'{1'b0, 13'd0, 13'd0, RGB_BLACK, 1'b0, NO_RESULT},
		'{1'b0, 13'd0, 13'd0, RGB_BLUE,  1'b0, NO_RESULT},
		'{1'b0, 13'd0, 13'd0, 24'hFF00FF, 1'b0, NO_RESULT},
		'{1'b0, 13'd0, 13'd0, RGB_RED,   1'b0, NO_RESULT},
		'{1'b0, 13'd0, 13'd0, 24'h00FFFF, 1'b0, NO_RESULT},
		'{1'b0, 13'd0, 13'd0, 24'h808080, 1'b0, NO_RESULT},
		'{1'b1, 13'd0, 13'd0, RGB_GREEN, 1'b1, '{8'd150, 1'b1, 8'd44,  8'd21,  1'b1}}
	};

	localparam logic [CFG_W-1:0] BIG_W [3] = '{13'd48, 13'd47, 13'd1};
	localparam logic [CFG_W-1:0] BIG_H [3] = '{13'd3, 13'd2, 13'd24};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [PIX_W-1:0]     red;
	logic [PIX_W-1:0]     green;
	logic [PIX_W-1:0]     blue;
	logic                 out_valid;
	logic                 out_ready;
	logic [PIX_W-1:0]     luma;
	logic                 chroma_valid;
	logic [PIX_W-1:0]     blue_diff;
	logic [PIX_W-1:0]     red_diff;
	logic                 frame_end;

	// typed expectation travels with the pixel on the input channel
	logic                 typed_chk;
	yuv_t                 typed_yuv;

	// converter state as the checker sees it
	logic [CFG_W-1:0]     size_w;
	logic [CFG_W-1:0]     size_h;
	int unsigned          col_pos;
	int unsigned          row_pos;
	logic [8:0]           hold_u;
	logic [8:0]           hold_v;
	logic [9:0]           top_u [STORE_COLS];
	logic [9:0]           top_v [STORE_COLS];

	yuv_t                 pending_yuv [$];
	bit                   idle_on;
	int                   mismatch_count;
	int                   pixels_in;
	int                   frames_out;
	int                   chroma_out;
	int                   size_settings;

	rgb_to_yuv420_converter_top #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.red(red),
		.green(green),
		.blue(blue),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.luma(luma),
		.chroma_valid(chroma_valid),
		.blue_diff(blue_diff),
		.red_diff(red_diff),
		.frame_end(frame_end)
	);

	always #4 clk = ~clk;

	function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v, input int unsigned top);
		if (v == 0)
			return 1;
		if (v > top)
			return top;
		return v;
	endfunction

	// luma for the pixel, chroma when it closes a block; advance the raster position
	function automatic yuv_t next_yuv(input logic [PIX_W-1:0] r8, g8, b8);
		int unsigned w_eff, h_eff, r, g, b, yy, uu, vv, su, sv, shift, blk;
		logic end_col, end_row;
		yuv_t res;
		w_eff = clamp_size(size_w, MAX_W);
		h_eff = clamp_size(size_h, MAX_H);
		end_col = col_pos >= w_eff - 1;
		end_row = row_pos >= h_eff - 1;
		blk = col_pos >> 1;
		r = r8;
		g = g8;
		b = b8;
		yy = (KY_R * r + KY_G * g + KY_B * b + KY_HALF) >> 16;
		uu = (K_CHROMA_BIAS + KU_B * b - KU_R * r - KU_G * g) >> 16;
		vv = (K_CHROMA_BIAS + KV_R * r - KV_G * g - KV_B * b) >> 16;
		res = '0;
		res.luma = yy[7:0];
		if (!col_pos[0] && !end_col) begin
			hold_u = uu[8:0];
			hold_v = vv[8:0];
		end else begin
			su = uu;
			sv = vv;
			shift = 0;
			if (col_pos[0]) begin
				su += hold_u;
				sv += hold_v;
				shift = 1;
			end
			if (!row_pos[0] && !end_row) begin
				top_u[blk] = su[9:0];
				top_v[blk] = sv[9:0];
			end else begin
				if (row_pos[0]) begin
					su += top_u[blk];
					sv += top_v[blk];
					shift += 1;
				end
				su = su >> shift;
				sv = sv >> shift;
				res.chroma_valid = 1'b1;
				res.blue_diff = (su > 255) ? PIX_MAX : su[7:0];
				res.red_diff = (sv > 255) ? PIX_MAX : sv[7:0];
			end
		end
		res.frame_end = end_col && end_row;
		if (end_col) begin
			col_pos = 0;
			row_pos = end_row ? 0 : row_pos + 1;
		end else begin
			col_pos += 1;
		end
		return res;
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		if (mismatch_count <= SHOW_LIMIT)
			$display("%0t ns: %s mismatch, got %0d, want %0d", $time, what, got, want);
	endtask

	// predict on each input transaction, check each output transaction
	always @(posedge clk) begin : watch
		yuv_t got;
		yuv_t want;
		yuv_t guess;
		if (in_valid && in_ready) begin
			guess = next_yuv(red, green, blue);
			pending_yuv.push_back(typed_chk ? typed_yuv : guess);
			pixels_in++;
		end
		if (out_valid && out_ready) begin
			got.luma = luma;
			got.chroma_valid = chroma_valid;
			got.blue_diff = blue_diff;
			got.red_diff = red_diff;
			got.frame_end = frame_end;
			if (pending_yuv.size() == 0) begin
				flag_mismatch("unexpected result, luma", got.luma, 0);
			end else begin
				want = pending_yuv.pop_front();
				if (got.luma !== want.luma)
					flag_mismatch("luma", got.luma, want.luma);
				if (got.chroma_valid !== want.chroma_valid)
					flag_mismatch("chroma_valid", got.chroma_valid, want.chroma_valid);
				if (got.blue_diff !== want.blue_diff)
					flag_mismatch("blue_diff", got.blue_diff, want.blue_diff);
				if (got.red_diff !== want.red_diff)
					flag_mismatch("red_diff", got.red_diff, want.red_diff);
				if (got.frame_end !== want.frame_end)
					flag_mismatch("frame_end", got.frame_end, want.frame_end);
				if (want.chroma_valid)
					chroma_out++;
				if (want.frame_end)
					frames_out++;
			end
		end
	end

	// output back-pressure in bursts while idling is on, else out_ready stays high
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (idle_on && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	task automatic set_frame_size(input logic [CFG_W-1:0] w, h, input bit wr_w, wr_h);
		if (wr_w) begin
			cfg_write_en <= 1'b1;
			cfg_index <= REG_FRAME_WIDTH;
			cfg_data <= w;
			@(posedge clk);
			size_w = w;
		end
		if (wr_h) begin
			cfg_write_en <= 1'b1;
			cfg_index <= REG_FRAME_HEIGHT;
			cfg_data <= h;
			@(posedge clk);
			size_h = h;
		end
		cfg_write_en <= 1'b0;
		size_settings++;
	endtask

	task automatic send_pixel(input logic [23:0] rgb, input logic chk, input yuv_t want);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		red <= rgb[23:16];
		green <= rgb[15:8];
		blue <= rgb[7:0];
		typed_chk <= chk;
		typed_yuv <= want;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// drop valid and wait until every pixel sent has come out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_yuv.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] pick_level();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [23:0] pick_rgb(input int mode, input logic [23:0] flat_rgb);
		if (mode == 2)
			return flat_rgb;
		if (mode == 1)
			return {{8{1'($urandom_range(0, 1))}}, {8{1'($urandom_range(0, 1))}},
				{8{1'($urandom_range(0, 1))}}};
		return {pick_level(), pick_level(), pick_level()};
	endfunction

	initial begin : stimulus
		int random_sent;
		int frames;
		int mode;
		int frame_px;
		logic [CFG_W-1:0] w;
		logic [CFG_W-1:0] h;
		logic [23:0] flat_rgb;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index = REG_FRAME_WIDTH;
		cfg_data = '0;
		in_valid = 1'b0;
		red = '0;
		green = '0;
		blue = '0;
		typed_chk = 1'b0;
		typed_yuv = NO_RESULT;
		size_w = FRAME_WIDTH_RST;
		size_h = FRAME_HEIGHT_RST;
		col_pos = 0;
		row_pos = 0;
		hold_u = '0;
		hold_v = '0;
		idle_on = 1'b1;
		random_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[i]) begin
			if (DIRECTED_ROWS[i].set_size) begin
				drain();
				set_frame_size(DIRECTED_ROWS[i].width, DIRECTED_ROWS[i].height, 1'b1, 1'b1);
			end
			send_pixel(DIRECTED_ROWS[i].rgb, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
		end
		drain();

		// whole frames only, so size changes always land on a frame boundary
		while (random_sent < RANDOM_PIXELS) begin
			w = ($urandom_range(0, 7) == 0) ? 13'($urandom_range(13, 48)) :
				13'($urandom_range(0, 12));
			h = ($urandom_range(0, 7) == 0) ? 13'($urandom_range(11, 24)) :
				13'($urandom_range(0, 10));
			set_frame_size(w, h, $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
			idle_on = $urandom_range(0, 3) != 0;
			mode = $urandom_range(0, 3) == 0 ? 2 : $urandom_range(0, 1);
			frame_px = clamp_size(size_w, MAX_W) * clamp_size(size_h, MAX_H);
			frames = (frame_px > 200) ? 1 : $urandom_range(1, 3);
			repeat (frames) begin
				flat_rgb = pick_rgb(1, RGB_BLACK);
				repeat (frame_px) begin
					send_pixel(pick_rgb(mode, flat_rgb), 1'b0, NO_RESULT);
					random_sent++;
				end
			end
			drain();
		end

		// wide and tall frames with no idling, each drained before the next size is set
		idle_on = 1'b0;
		foreach (BIG_W[i]) begin
			set_frame_size(BIG_W[i], BIG_H[i], 1'b1, 1'b1);
			repeat (clamp_size(size_w, MAX_W) * clamp_size(size_h, MAX_H))
				send_pixel(pick_rgb(0, RGB_BLACK), 1'b0, NO_RESULT);
			drain();
		end
		repeat (12) @(posedge clk);

		$display("Checked %0d pixels over %0d frames, %0d of them closing a chroma block,",
			pixels_in, frames_out, chroma_out);
		$display("across %0d size settings from 1x1 up to 48-wide and 24-tall frames.",
			size_settings);
		if (mismatch_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Watchdog expired with %0d results outstanding", pending_yuv.size());
		$display("tb NOT OK");
		$finish;
	end

endmodule

[files.f]
hw/rtl/rgb2yuv_pkg.sv
hw/rtl/rgb_to_yuv420_converter_top.sv
tb/sv/tb.sv
